// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define RMQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rmq_pkg.sv =====
// Shared types and codes for the rotation matrix to quaternion pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int LANES = 3;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // Control group that travels alongside every word in the pipeline.
  typedef struct packed {
    logic             valid;
    logic             degen;
    logic [1:0]       br;
    logic [LANES-1:0] neg;
  } ctl_t;

endpackage
`default_nettype wire

// ===== src/rmq_front.sv =====
// Input stage: branch choice, radicand and numerators of one matrix.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front #(
  parameter int W  = 16,
  parameter int F  = 14,
  parameter int RW = 19,
  parameter int SB = 32,
  parameter int DB = 31
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [9*W-1:0]      mat,
  output rmq_pkg::ctl_t            ctl_o,
  output logic [SB-1:0]            rad_o,
  output logic [3*DB-1:0]          x_o
);

  logic signed [W-1:0]  a [0:8];
  logic signed [W+1:0]  trace;
  logic signed [RW-1:0] one_c;
  logic signed [RW-1:0] rad;
  logic [1:0]           br;
  logic signed [W:0]    num [0:2];
  logic [W:0]           mag [0:2];
  logic [2:0]           neg;
  logic                 degen;

  rmq_pkg::ctl_t        ctl_r, ctl_nxt;
  logic [SB-1:0]        rad_r, rad_nxt;
  logic [3*DB-1:0]      x_r, x_nxt;

  genvar g;
  generate
    for (g = 0; g < 9; g++) begin : g_el
      assign a[g] = mat[g*W +: W];
    end
  endgenerate

  assign one_c = RW'(1) << F;
  assign trace = (W+2)'(a[0]) + (W+2)'(a[4]) + (W+2)'(a[8]);

  always_comb begin
    priority if (trace > 0) begin
      br  = rmq_pkg::BR_TRACE;
      rad = one_c + RW'(trace);
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      br  = rmq_pkg::BR_X;
      rad = one_c + RW'(a[0]) - RW'(a[4]) - RW'(a[8]);
    end else if (a[4] > a[8]) begin
      br  = rmq_pkg::BR_Y;
      rad = one_c + RW'(a[4]) - RW'(a[0]) - RW'(a[8]);
    end else begin
      br  = rmq_pkg::BR_Z;
      rad = one_c + RW'(a[8]) - RW'(a[0]) - RW'(a[4]);
    end
  end

  // Element order: 0 r00, 1 r01, 2 r02, 3 r10, 4 r11, 5 r12, 6 r20, 7 r21, 8 r22.
  // The three lanes carry the non-branch components in x, y, z, w order.
  always_comb begin
    unique case (br)
      rmq_pkg::BR_TRACE: begin
        num[0] = (W+1)'(a[7]) - (W+1)'(a[5]);
        num[1] = (W+1)'(a[2]) - (W+1)'(a[6]);
        num[2] = (W+1)'(a[3]) - (W+1)'(a[1]);
      end
      rmq_pkg::BR_X: begin
        num[0] = (W+1)'(a[1]) + (W+1)'(a[3]);
        num[1] = (W+1)'(a[2]) + (W+1)'(a[6]);
        num[2] = (W+1)'(a[7]) - (W+1)'(a[5]);
      end
      rmq_pkg::BR_Y: begin
        num[0] = (W+1)'(a[1]) + (W+1)'(a[3]);
        num[1] = (W+1)'(a[5]) + (W+1)'(a[7]);
        num[2] = (W+1)'(a[2]) - (W+1)'(a[6]);
      end
      default: begin
        num[0] = (W+1)'(a[2]) + (W+1)'(a[6]);
        num[1] = (W+1)'(a[5]) + (W+1)'(a[7]);
        num[2] = (W+1)'(a[3]) - (W+1)'(a[1]);
      end
    endcase
  end

  generate
    for (g = 0; g < 3; g++) begin : g_num
      assign neg[g] = num[g][W];
      assign mag[g] = num[g][W] ? (W+1)'(-num[g]) : (W+1)'(num[g]);
      assign x_nxt[g*DB +: DB] = DB'(mag[g]) << F;
    end
  endgenerate

  assign degen   = (rad <= 0);
  assign rad_nxt = degen ? '0 : (SB'(rad[RW-2:0]) << F);

  always_comb begin
    ctl_nxt.valid = in_valid;
    ctl_nxt.degen = degen;
    ctl_nxt.br    = br;
    ctl_nxt.neg   = neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rad_nxt;
      x_r   <= x_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rad_o = rad_r;
  assign x_o   = x_r;

endmodule
`default_nettype wire

// ===== src/rmq_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per cell.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_cell #(
  parameter int NR = 16,
  parameter int SB = 32,
  parameter int PW = 93
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire rmq_pkg::ctl_t  ctl_i,
  input  wire logic [SB-1:0]  rad_i,
  input  wire logic [NR+1:0]  rem_i,
  input  wire logic [NR-1:0]  root_i,
  input  wire logic [PW-1:0]  pay_i,
  output rmq_pkg::ctl_t       ctl_o,
  output logic [SB-1:0]       rad_o,
  output logic [NR+1:0]       rem_o,
  output logic [NR-1:0]       root_o,
  output logic [PW-1:0]       pay_o
);

  logic [NR+3:0] rem_w;
  logic [NR+3:0] trial;
  logic [NR+3:0] diff;
  logic          ge;

  rmq_pkg::ctl_t  ctl_r;
  logic [SB-1:0]  rad_r, rad_nxt;
  logic [NR+1:0]  rem_r, rem_nxt;
  logic [NR-1:0]  root_r, root_nxt;
  logic [PW-1:0]  pay_r;

  // Bring down the next two radicand bits and try root*4+1.
  assign rem_w   = {rem_i, rad_i[SB-1:SB-2]};
  assign trial   = {2'b00, root_i, 2'b01};
  assign diff    = rem_w - trial;
  assign ge      = (rem_w >= trial);
  assign rem_nxt = ge ? diff[NR+1:0] : rem_w[NR+1:0];
  assign root_nxt = {root_i[NR-2:0], ge};
  assign rad_nxt = rad_i << 2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pay_r  <= pay_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pay_o  = pay_r;

endmodule
`default_nettype wire

// ===== src/rmq_div_cell.sv =====
// One cell of the divider chain: one quotient bit for each of three lanes.
// Depends on rmq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_cell #(
  parameter int DW = 17,
  parameter int DB = 31
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire rmq_pkg::ctl_t    ctl_i,
  input  wire logic [DW-1:0]    d_i,
  input  wire logic [3*DW-1:0]  rem_i,
  input  wire logic [3*DB-1:0]  x_i,
  output rmq_pkg::ctl_t         ctl_o,
  output logic [DW-1:0]         d_o,
  output logic [3*DW-1:0]       rem_o,
  output logic [3*DB-1:0]       x_o
);

  rmq_pkg::ctl_t    ctl_r;
  logic [DW-1:0]    d_r;
  logic [3*DW-1:0]  rem_r, rem_nxt;
  logic [3*DB-1:0]  x_r, x_nxt;

  // The dividend shifts out at the top while quotient bits shift in below.
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      logic [DW:0] rem_w;
      logic [DW:0] diff;
      logic        ge;
      assign rem_w = {rem_i[g*DW +: DW], x_i[g*DB + DB - 1]};
      assign diff  = rem_w - {1'b0, d_i};
      assign ge    = (rem_w >= {1'b0, d_i});
      assign rem_nxt[g*DW +: DW] = ge ? diff[DW-1:0] : rem_w[DW-1:0];
      assign x_nxt[g*DB +: DB]   = {x_i[g*DB +: DB-1], ge};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_i;
      rem_r <= rem_nxt;
      x_r   <= x_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign d_o   = d_r;
  assign rem_o = rem_r;
  assign x_o   = x_r;

endmodule
`default_nettype wire

// ===== src/rotation_matrix_to_quaternion_top.sv =====
// Top level: input stage, square root cells, divider cells, output skid.
// Depends on rmq_pkg, rmq_front, rmq_sqrt_cell and rmq_div_cell.
//
//   Channel | Ports      | tdata (low bit up)               | tuser
//   in      | in_t*      | r00 r01 r02 r10 r11 r12 r20 r21 r22 | none
//   out     | out_t*     | qx qy qz qw                      | branch_taken, degenerate
//
// One word per cycle is accepted and delivered when out_tready stays high.
// A word passes the input stage, the square root cells with one root bit per cell,
// the divider cells with one quotient bit per cell, and the output register.
// Reset clears all valid flags; no clearing pass is needed.
// A stalled output parks one word in the skid register and then in_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_top #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, zero fill
  input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // qx, qy, qz, qw, zero fill
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]        out_tdata,
  // branch_taken [1:0], degenerate [2]
  output logic [2:0]                               out_tuser
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int OUTW = ((4*W+7)/8)*8;
  localparam int RW   = ((W > F+1) ? W : F+1) + 3;
  localparam int SB   = RW - 1 + F + ((RW - 1 + F) % 2);
  localparam int NR   = SB / 2;
  localparam int DB   = W + 1 + F;
  localparam int DW   = NR + 1;
  localparam int PW   = 3 * DB;

  localparam logic [DB-1:0] ONE_DB  = 1;
  localparam logic [DB-1:0] MAXNEG  = ONE_DB << (W-1);
  localparam logic [DB-1:0] MAXPOS  = MAXNEG - ONE_DB;

  logic adv;

  rmq_pkg::ctl_t   f_ctl;
  logic [SB-1:0]   f_rad;
  logic [PW-1:0]   f_x;

  rmq_pkg::ctl_t   s_ctl  [0:NR];
  logic [SB-1:0]   s_rad  [0:NR];
  logic [NR+1:0]   s_rem  [0:NR];
  logic [NR-1:0]   s_root [0:NR];
  logic [PW-1:0]   s_pay  [0:NR];

  rmq_pkg::ctl_t   d_ctl [0:DB];
  logic [DW-1:0]   d_d   [0:DB];
  logic [3*DW-1:0] d_rem [0:DB];
  logic [PW-1:0]   d_x   [0:DB];

  rmq_front #(.W(W), .F(F), .RW(RW), .SB(SB), .DB(DB)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .mat      (in_tdata[9*W-1:0]),
    .ctl_o    (f_ctl),
    .rad_o    (f_rad),
    .x_o      (f_x)
  );

  assign s_ctl[0]  = f_ctl;
  assign s_rad[0]  = f_rad;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_pay[0]  = f_x;

  genvar g;
  generate
    for (g = 0; g < NR; g++) begin : g_sqrt
      rmq_sqrt_cell #(.NR(NR), .SB(SB), .PW(PW)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .ctl_i  (s_ctl[g]),
        .rad_i  (s_rad[g]),
        .rem_i  (s_rem[g]),
        .root_i (s_root[g]),
        .pay_i  (s_pay[g]),
        .ctl_o  (s_ctl[g+1]),
        .rad_o  (s_rad[g+1]),
        .rem_o  (s_rem[g+1]),
        .root_o (s_root[g+1]),
        .pay_o  (s_pay[g+1])
      );
    end
  endgenerate

  // The divisor is twice the root.
  assign d_ctl[0] = s_ctl[NR];
  assign d_d[0]   = {s_root[NR], 1'b0};
  assign d_rem[0] = '0;
  assign d_x[0]   = s_pay[NR];

  generate
    for (g = 0; g < DB; g++) begin : g_div
      rmq_div_cell #(.DW(DW), .DB(DB)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .ctl_i (d_ctl[g]),
        .d_i   (d_d[g]),
        .rem_i (d_rem[g]),
        .x_i   (d_x[g]),
        .ctl_o (d_ctl[g+1]),
        .d_o   (d_d[g+1]),
        .rem_o (d_rem[g+1]),
        .x_o   (d_x[g+1])
      );
    end
  endgenerate

  function automatic logic [W-1:0] sat_lane(input logic neg, input logic [DB-1:0] m);
    logic [W-1:0] r;
    if (neg && m != '0) begin
      if (m > MAXNEG) begin
        r = MAXNEG[W-1:0];
      end else begin
        r = W'(-m[W-1:0]);
      end
    end else if (m > MAXPOS) begin
      r = MAXPOS[W-1:0];
    end else begin
      r = m[W-1:0];
    end
    return r;
  endfunction

  rmq_pkg::ctl_t t_ctl;
  logic [W-1:0]  lane [0:2];
  logic [W-1:0]  big;
  logic [W-1:0]  qx, qy, qz, qw;
  logic [OUTW-1:0] t_data;
  logic [2:0]    t_user;
  logic          push;

  logic            out_valid_r, out_valid_nxt;
  logic [OUTW-1:0] out_data_r, out_data_nxt;
  logic [2:0]      out_user_r, out_user_nxt;
  logic            skid_valid_r, skid_valid_nxt;
  logic [OUTW-1:0] skid_data_r;
  logic [2:0]      skid_user_r;
  logic            take_skid;
  logic            load_skid;

  assign t_ctl = d_ctl[DB];
  assign big   = sat_lane(1'b0, DB'(d_d[DB] >> 2));

  generate
    for (g = 0; g < 3; g++) begin : g_sat
      assign lane[g] = sat_lane(t_ctl.neg[g], d_x[DB][g*DB +: DB]);
    end
  endgenerate

  always_comb begin
    unique case (t_ctl.br)
      rmq_pkg::BR_TRACE: begin
        qx = lane[0]; qy = lane[1]; qz = lane[2]; qw = big;
      end
      rmq_pkg::BR_X: begin
        qx = big; qy = lane[0]; qz = lane[1]; qw = lane[2];
      end
      rmq_pkg::BR_Y: begin
        qx = lane[0]; qy = big; qz = lane[1]; qw = lane[2];
      end
      default: begin
        qx = lane[0]; qy = lane[1]; qz = big; qw = lane[2];
      end
    endcase
  end

  assign t_data = t_ctl.degen ? '0 : OUTW'({qw, qz, qy, qx});
  assign t_user = {t_ctl.degen, t_ctl.br};
  assign adv    = !skid_valid_r;
  assign push   = adv && t_ctl.valid;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    skid_valid_nxt = skid_valid_r;
    take_skid      = 1'b0;
    load_skid      = 1'b0;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        out_user_nxt   = skid_user_r;
        skid_valid_nxt = 1'b0;
        take_skid      = 1'b1;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = t_data;
        out_user_nxt  = t_user;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      load_skid      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    if (load_skid && !take_skid) begin
      skid_data_r <= t_data;
      skid_user_r <= t_user;
    end
  end

  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ===== src/rmq_checker.sv =====
// Port-level checks for the quaternion block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rmq_checker #(
  parameter int DATA_WIDTH = 16
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]   out_tdata,
  input wire logic [2:0]                          out_tuser
);

  `RMQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "held")
  `RMQ_ASSERT(a_degen_zero, out_tvalid && out_tuser[2] |-> out_tdata == '0, "degenerate word")
  `RMQ_ASSERT(a_ready_low, !in_tready |-> out_tvalid, "input held off with no output")
  `RMQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
